FILE: rtl/core/acm_pkg.sv
`default_nettype none
package acm_pkg;
  localparam int MEM_WORDS = 256;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = $clog2(MEM_WORDS);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [WORD_BITS-1:0] word_t;

  // item kinds
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_EXEC    = 2'd2;

  // run status codes
  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_HALT   = 2'd1;
  localparam logic [1:0] ST_BADOP  = 2'd2;
  localparam logic [1:0] ST_DIVZ   = 2'd3;

  // opcodes
  localparam word_t OPC_ADD    = word_t'(1);
  localparam word_t OPC_SUB    = word_t'(2);
  localparam word_t OPC_MUL    = word_t'(3);
  localparam word_t OPC_DIV    = word_t'(4);
  localparam word_t OPC_JMP    = word_t'(5);
  localparam word_t OPC_JMPN   = word_t'(6);
  localparam word_t OPC_JMPP   = word_t'(7);
  localparam word_t OPC_JMPZ   = word_t'(8);
  localparam word_t OPC_COPY   = word_t'(9);
  localparam word_t OPC_LOAD   = word_t'(10);
  localparam word_t OPC_STORE  = word_t'(11);
  localparam word_t OPC_INPUT  = word_t'(12);
  localparam word_t OPC_OUTPUT = word_t'(13);
  localparam word_t OPC_STOP   = word_t'(14);

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  address;
    logic [31:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pc_out;
    logic [31:0] acc_out;
    logic        out_valid;
    logic [31:0] out_value;
    logic [1:0]  status;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/acm_div.sv
`default_nettype none
module acm_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire acm_pkg::div_req_t req,
  output acm_pkg::div_rsp_t      rsp
);
  import acm_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS + 1);

  logic              busy;
  logic              done;
  logic [CNT_BITS-1:0] cnt;
  word_t             rem;
  word_t             quo;
  word_t             dvs;
  logic              neg;
  logic [WORD_BITS:0] trial;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quo[WORD_BITS-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(WORD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend[WORD_BITS-1] ? word_t'(-req.dividend) : req.dividend;
      dvs <= req.divisor[WORD_BITS-1] ? word_t'(-req.divisor) : req.divisor;
      neg <= req.dividend[WORD_BITS-1] ^ req.divisor[WORD_BITS-1];
    end else if (busy) begin
      if (!trial[WORD_BITS]) begin
        rem <= trial[WORD_BITS-1:0];
        quo <= {quo[WORD_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[WORD_BITS-2:0], quo[WORD_BITS-1]};
        quo <= {quo[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? word_t'(-quo) : quo;
endmodule
`default_nettype wire

FILE: rtl/core/acm_mem.sv
`default_nettype none
module acm_mem (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire acm_pkg::addr_t waddr,
  input  wire acm_pkg::word_t wdata,
  input  wire acm_pkg::addr_t raddr,
  output acm_pkg::word_t     rdata
);
  import acm_pkg::*;

  word_t mem [MEM_WORDS];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/accumulator_machine_core.sv
`default_nettype none
// channel   | signals                         | handshake
// item in   | start, busy, in_item            | taken when start && !busy
// config    | cfg_valid, cfg_ready, cfg_data  | written when cfg_valid && cfg_ready
// result    | result_valid, result            | one cycle strobe, cannot stall
//
// load, restart and undefined op keep busy high through WAIT and DONE; an
// instruction keeps it through the opcode, two operand words and the source
// word read one after another on the single read port, then execute and
// finish, plus S_MUL for MUL and the bit-serial divider for DIV; an execute
// while halted or at code_end goes straight to DONE. the result strobe comes
// in the cycle busy falls. rst is synchronous; memory content is not cleared.
module accumulator_machine_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire acm_pkg::in_item_t  in_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [8:0]         cfg_data,
  output logic                    result_valid,
  output acm_pkg::out_item_t      result
);
  import acm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDOPC = 10'b0000000010,
    S_RDA   = 10'b0000000100,
    S_RDB   = 10'b0000001000,
    S_RDSRC = 10'b0000010000,
    S_EXEC  = 10'b0000100000,
    S_MUL   = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  state_t   state;
  logic [8:0] code_end;
  addr_t    pc;
  word_t    acc;
  logic [1:0] run_status;
  in_item_t item;
  word_t    opc;
  addr_t    a_addr;
  addr_t    b_addr;
  word_t    src;
  word_t    prod;
  logic     ovalid;
  word_t    oval;

  logic     mem_we;
  addr_t    mem_waddr;
  word_t    mem_wdata;
  addr_t    mem_raddr;
  word_t    mem_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  acm_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  acm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // read address sequence: opcode, a, b, source
  always_comb begin
    mem_raddr = pc;
    unique case (state)
      S_RDOPC: mem_raddr = pc + addr_t'(1);
      S_RDA:   mem_raddr = pc + addr_t'(2);
      S_RDB:   mem_raddr = a_addr;
      default: mem_raddr = pc;
    endcase
  end

  // write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = a_addr;
    mem_wdata = acc;
    if (state == S_WAIT && item.op == OP_LOAD) begin
      mem_we    = 1'b1;
      mem_waddr = addr_t'(item.address);
      mem_wdata = item.data_word;
    end else if (state == S_EXEC) begin
      unique case (opc)
        OPC_COPY: begin
          mem_we    = 1'b1;
          mem_waddr = b_addr;
          mem_wdata = src;
        end
        OPC_STORE: mem_we = 1'b1;
        OPC_INPUT: begin
          mem_we    = 1'b1;
          mem_wdata = item.data_word;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  assign div_req.start    = (state == S_EXEC) && (opc == OPC_DIV) && (src != '0);
  assign div_req.dividend = acc;
  assign div_req.divisor  = src;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pc           <= '0;
      acc          <= '0;
      run_status   <= ST_RUN;
      code_end     <= 9'd256;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        code_end <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          ovalid <= 1'b0;
          oval   <= '0;
          if (start) begin
            item <= in_item;
            if (in_item.op == OP_EXEC) begin
              if (run_status != ST_RUN) begin
                state <= S_DONE;
              end else if ({1'b0, pc} >= code_end) begin
                run_status <= ST_HALT;
                state      <= S_DONE;
              end else begin
                state <= S_RDOPC;
              end
            end else begin
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (item.op == OP_RESTART) begin
            pc         <= '0;
            acc        <= '0;
            run_status <= ST_RUN;
          end
          state <= S_DONE;
        end
        S_RDOPC: begin
          opc   <= mem_rdata;
          state <= S_RDA;
        end
        S_RDA: begin
          a_addr <= mem_rdata[ADDR_BITS-1:0];
          state  <= S_RDB;
        end
        S_RDB: begin
          b_addr <= mem_rdata[ADDR_BITS-1:0];
          state  <= S_RDSRC;
        end
        S_RDSRC: begin
          src   <= mem_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_DONE;
          unique case (opc)
            OPC_ADD: begin
              acc <= acc + src;
              pc  <= pc + addr_t'(2);
            end
            OPC_SUB: begin
              acc <= acc - src;
              pc  <= pc + addr_t'(2);
            end
            OPC_MUL: begin
              prod  <= acc * src;
              state <= S_MUL;
            end
            OPC_DIV: begin
              if (src == '0) begin
                run_status <= ST_DIVZ;
              end else begin
                state <= S_DIV;
              end
            end
            OPC_JMP: pc <= a_addr;
            OPC_JMPN: pc <= acc[WORD_BITS-1] ? a_addr : pc + addr_t'(2);
            OPC_JMPP: pc <= (acc != '0 && !acc[WORD_BITS-1]) ? a_addr : pc + addr_t'(2);
            OPC_JMPZ: pc <= (acc == '0) ? a_addr : pc + addr_t'(2);
            OPC_COPY: pc <= pc + addr_t'(3);
            OPC_LOAD: begin
              acc <= src;
              pc  <= pc + addr_t'(2);
            end
            OPC_STORE, OPC_INPUT: pc <= pc + addr_t'(2);
            OPC_OUTPUT: begin
              ovalid <= 1'b1;
              oval   <= src;
              pc     <= pc + addr_t'(2);
            end
            OPC_STOP: begin
              pc         <= pc + addr_t'(1);
              run_status <= ST_HALT;
            end
            default: run_status <= ST_BADOP;
          endcase
        end
        S_MUL: begin
          acc   <= prod;
          pc    <= pc + addr_t'(2);
          state <= S_DONE;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            acc   <= div_rsp.quotient;
            pc    <= pc + addr_t'(2);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // end of program check after an executed instruction
          if (item.op == OP_EXEC && run_status == ST_RUN && {1'b0, pc} >= code_end) begin
            run_status <= ST_HALT;
          end
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result fields, combinational from the registers, so they show the final status with result_valid
  always_comb begin
    result.pc_out    = pc;
    result.acc_out   = acc;
    result.out_valid = ovalid;
    result.out_value = oval;
    result.status    = run_status;
  end
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import acm_pkg::*;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [8:0] cfg_data;
  logic      result_valid;
  out_item_t result;

  accumulator_machine_core uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  // machine state as the testbench predicts it
  word_t      mach_mem [MEM_WORDS];
  addr_t      mach_pc;
  word_t      mach_acc;
  logic [1:0] mach_status;
  logic [8:0] mach_code_end;

  out_item_t  pending_results [$];
  int         error_count;
  int         items_sent;
  int         send_idle;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // apply one item to the predicted machine and return the result it gives
  function automatic out_item_t next_machine_result(input in_item_t it);
    out_item_t  r;
    word_t      opc;
    word_t      src;
    word_t      acc;
    addr_t      pc;
    addr_t      pa1;
    addr_t      pa2;
    addr_t      a;
    addr_t      b;
    longint     q;
    logic       commit;
    r = '0;
    case (it.op)
      OP_LOAD: mach_mem[it.address] = it.data_word;
      OP_RESTART: begin
        mach_pc = '0;
        mach_acc = '0;
        mach_status = ST_RUN;
      end
      OP_EXEC: begin
        if (mach_status == ST_RUN) begin
          if ({1'b0, mach_pc} >= mach_code_end) begin
            mach_status = ST_HALT;
          end else begin
            pc = mach_pc;
            acc = mach_acc;
            pa1 = pc + 8'd1;
            pa2 = pc + 8'd2;
            opc = mach_mem[pc];
            a = mach_mem[pa1][7:0];
            b = mach_mem[pa2][7:0];
            src = mach_mem[a];
            commit = 1'b1;
            case (opc)
              OPC_ADD: begin acc = acc + src; pc = pc + 8'd2; end
              OPC_SUB: begin acc = acc - src; pc = pc + 8'd2; end
              OPC_MUL: begin acc = acc * src; pc = pc + 8'd2; end
              OPC_DIV: begin
                if (src == '0) begin
                  mach_status = ST_DIVZ;
                  commit = 1'b0;
                end else begin
                  // 64-bit quotient so the minimum over minus one wraps
                  q = longint'($signed(acc)) / longint'($signed(src));
                  acc = q[31:0];
                  pc = pc + 8'd2;
                end
              end
              OPC_JMP:  pc = a;
              OPC_JMPN: pc = acc[31] ? a : pc + 8'd2;
              OPC_JMPP: pc = (acc != '0 && !acc[31]) ? a : pc + 8'd2;
              OPC_JMPZ: pc = (acc == '0) ? a : pc + 8'd2;
              OPC_COPY: begin mach_mem[b] = src; pc = pc + 8'd3; end
              OPC_LOAD: begin acc = src; pc = pc + 8'd2; end
              OPC_STORE: begin mach_mem[a] = acc; pc = pc + 8'd2; end
              OPC_INPUT: begin mach_mem[a] = it.data_word; pc = pc + 8'd2; end
              OPC_OUTPUT: begin
                r.out_valid = 1'b1;
                r.out_value = src;
                pc = pc + 8'd2;
              end
              OPC_STOP: begin pc = pc + 8'd1; mach_status = ST_HALT; end
              default: begin
                mach_status = ST_BADOP;
                commit = 1'b0;
              end
            endcase
            if (commit) begin
              mach_pc = pc;
              mach_acc = acc;
              if (mach_status == ST_RUN && {1'b0, pc} >= mach_code_end)
                mach_status = ST_HALT;
            end
          end
        end
      end
      default: ;
    endcase
    r.pc_out = mach_pc;
    r.acc_out = mach_acc;
    r.status = mach_status;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result pc=%0d acc=%h status=%0d",
                   result.pc_out, result.acc_out, result.status);
      end else begin
        e = pending_results.pop_front();
        if (result.pc_out !== e.pc_out || result.acc_out !== e.acc_out ||
            result.out_valid !== e.out_valid || result.out_value !== e.out_value ||
            result.status !== e.status) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch exp pc=%0d acc=%h ov=%b oval=%h st=%0d",
                     e.pc_out, e.acc_out, e.out_valid, e.out_value, e.status);
            $display("         got pc=%0d acc=%h ov=%b oval=%h st=%0d",
                     result.pc_out, result.acc_out, result.out_valid,
                     result.out_value, result.status);
          end
        end
      end
    end
  end

  // send one item, with random idle cycles ahead of it
  task automatic send_item(input in_item_t it);
    out_item_t expected;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    expected = next_machine_result(it);
    pending_results = {pending_results, expected};
    items_sent++;
  endtask

  task automatic load_word(input logic [7:0] addr, input word_t w);
    in_item_t it;
    it.op = OP_LOAD;
    it.address = addr;
    it.data_word = w;
    send_item(it);
  endtask

  task automatic restart_machine();
    in_item_t it;
    it.op = OP_RESTART;
    it.address = 8'($urandom);
    it.data_word = $urandom;
    send_item(it);
  endtask

  task automatic exec_step();
    in_item_t it;
    it.op = OP_EXEC;
    it.address = 8'($urandom);
    it.data_word = $urandom;
    send_item(it);
  endtask

  task automatic send_undefined_op();
    in_item_t it;
    it.op = 2'd3;
    it.address = 8'($urandom);
    it.data_word = $urandom;
    send_item(it);
  endtask

  // write code_end once the machine is idle
  task automatic set_code_end(input logic [8:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mach_code_end = v;
  endtask

  // every word gets written so no read ever hits an unwritten entry
  task automatic test_fill_memory();
    for (int i = 0; i < MEM_WORDS; i++)
      load_word(8'(i), (i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h7fff_ffff :
                       (i == 2) ? 32'hffff_ffff : word_t'($urandom));
  endtask

  // acc loaded from 200, then one instruction with operand 201 (and 202 for copy)
  task automatic try_instruction(input word_t opc, input word_t acc0, input word_t val);
    load_word(8'd2, opc);
    load_word(8'd200, acc0);
    load_word(8'd201, val);
    restart_machine();
    repeat (3) exec_step();
  endtask

  task automatic test_opcodes();
    load_word(8'd0, OPC_LOAD);
    load_word(8'd1, 32'd200);
    load_word(8'd3, 32'd201);
    load_word(8'd4, 32'd202);
    try_instruction(OPC_ADD, 32'h7fff_ffff, 32'd1);
    try_instruction(OPC_SUB, 32'h8000_0000, 32'd1);
    try_instruction(OPC_MUL, 32'h1234_5678, 32'hffff_fffd);
    try_instruction(OPC_DIV, -32'sd7, 32'd2);
    try_instruction(OPC_DIV, 32'h8000_0000, 32'hffff_ffff);
    try_instruction(OPC_DIV, 32'd5, 32'd0);
    try_instruction(OPC_JMP, 32'd1, 32'd0);
    try_instruction(OPC_JMPN, 32'hffff_fff0, 32'd0);
    try_instruction(OPC_JMPN, 32'd3, 32'd0);
    try_instruction(OPC_JMPP, 32'd3, 32'd0);
    try_instruction(OPC_JMPP, 32'd0, 32'd0);
    try_instruction(OPC_JMPZ, 32'd0, 32'd0);
    try_instruction(OPC_JMPZ, 32'd9, 32'd0);
    try_instruction(OPC_COPY, 32'd1, 32'hdead_beef);
    try_instruction(OPC_LOAD, 32'd1, 32'h8000_0001);
    try_instruction(OPC_STORE, 32'hcafe_f00d, 32'd7);
    try_instruction(OPC_INPUT, 32'd1, 32'd7);
    try_instruction(OPC_OUTPUT, 32'd1, 32'h5555_aaaa);
    try_instruction(OPC_STOP, 32'd1, 32'd7);
    try_instruction(32'd0, 32'd1, 32'd7);
    try_instruction(32'd15, 32'd1, 32'd7);
    try_instruction(32'hffff_ffff, 32'd1, 32'd7);
    // execute while halted and the undefined op
    exec_step();
    send_undefined_op();
  endtask

  // jump target and operand fetch that wrap around the end of memory
  task automatic test_address_wrap();
    load_word(8'd0, OPC_JMP);
    load_word(8'd1, 32'hffff_fffe);
    load_word(8'd254, OPC_ADD);
    load_word(8'd255, 32'h0000_0100);
    restart_machine();
    repeat (3) exec_step();
  endtask

  // halting on code_end before and after an instruction
  task automatic test_code_end();
    load_word(8'd0, OPC_LOAD);
    load_word(8'd1, 32'd200);
    load_word(8'd2, OPC_ADD);
    load_word(8'd3, 32'd201);
    set_code_end(9'd3);
    restart_machine();
    repeat (3) exec_step();
    set_code_end(9'd1);
    restart_machine();
    repeat (2) exec_step();
    set_code_end(9'd2);
    restart_machine();
    exec_step();
    set_code_end(9'd256);
  endtask

  // random program, random data, then run it until it stops or 30 steps have run
  task automatic run_random_program();
    int         len;
    int         p;
    int         steps;
    word_t      opc;
    logic [7:0] tgt;
    len = $urandom_range(3, 24);
    p = 0;
    while (p < len) begin
      if ($urandom_range(99) < 5) opc = $urandom;
      else opc = word_t'($urandom_range(1, 14));
      load_word(8'(p), opc);
      for (int k = 1; k <= ((opc == OPC_COPY) ? 2 : 1); k++) begin
        if (opc >= OPC_JMP && opc <= OPC_JMPZ) tgt = 8'($urandom_range(0, len - 1));
        else tgt = 8'($urandom_range(128, 255));
        load_word(8'(p + k), ($urandom_range(3) == 0) ? {24'($urandom), tgt} : {24'd0, tgt});
      end
      p = p + ((opc == OPC_COPY) ? 3 : 2);
    end
    for (int k = 0; k < 6; k++)
      load_word(8'($urandom_range(128, 255)),
                ($urandom_range(7) == 0) ? 32'd0 :
                ($urandom_range(1) == 0) ? word_t'($urandom_range(0, 20)) - 32'd10 :
                word_t'($urandom));
    if ($urandom_range(4) == 0) set_code_end(9'($urandom_range(1, 256)));
    restart_machine();
    steps = 0;
    while (steps < 30) begin
      if ($urandom_range(19) == 0) send_undefined_op();
      if ($urandom_range(19) == 0) load_word(8'($urandom), $urandom);
      exec_step();
      steps++;
      if (mach_status != ST_RUN) steps = 30;
    end
    exec_step();
  endtask

  task automatic test_random(input int target);
    while (items_sent < target) run_random_program();
  endtask

  initial begin
    int idle_plan [4];
    idle_plan = '{0, 75, 0, 33};
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    error_count = 0;
    items_sent = 0;
    send_idle = 0;
    mach_pc = '0;
    mach_acc = '0;
    mach_status = ST_RUN;
    mach_code_end = 9'd256;
    for (int i = 0; i < MEM_WORDS; i++) mach_mem[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_memory();
    test_opcodes();
    test_address_wrap();
    test_code_end();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_plan[ph];
      test_random(400 + 175 * (ph + 1));
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0) $display("[accumulator_machine_core] OK");
    else $display("[accumulator_machine_core] ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("[accumulator_machine_core] ERROR");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/acm_pkg.sv
rtl/core/acm_div.sv
rtl/core/acm_mem.sv
rtl/core/accumulator_machine_core.sv
tb/testbench.sv
